>>> rtl/pge_pkg.sv
// Package for the periodic Gaussian envelope block: widths, types, exp table.
// No dependencies.
package pge_pkg;

  localparam int CoordW = 16;
  localparam int CfgW   = 48;
  localparam int OutW   = 17;
  localparam int AccW   = 50;

  localparam logic [30:0] Log2eQ30 = 31'd1549082005;
  localparam logic [29:0] Ln2Q30   = 30'd744261118;
  localparam logic [30:0] OneQ30   = 31'd1073741824;
  localparam logic [AccW-1:0] ExpCutoff = AccW'(64'd12 << 28);
  localparam logic [OutW-1:0] OutMax = 17'd65536;
  // ceil(2^20 / 6): x * Recip6 >> 20 is floor(x / 6) for x below 2^19
  localparam logic [17:0] Recip6 = 18'd174763;

  localparam logic [1:0] RegFloor = 2'd3;

  typedef struct packed {
    logic signed [16:0] dx;
    logic [AccW-1:0]    acc;
  } cell_data_t;

  function automatic logic [30:0] pow2_neg(input logic [3:0] i);
    logic [30:0] v;
    case (i)
      4'd0:  v = 31'd1073741824;
      4'd1:  v = 31'd1028218693;
      4'd2:  v = 31'd984625594;
      4'd3:  v = 31'd942880699;
      4'd4:  v = 31'd902905651;
      4'd5:  v = 31'd864625413;
      4'd6:  v = 31'd827968132;
      4'd7:  v = 31'd792865000;
      4'd8:  v = 31'd759250125;
      4'd9:  v = 31'd727060410;
      4'd10: v = 31'd696235434;
      4'd11: v = 31'd666717336;
      4'd12: v = 31'd638450708;
      4'd13: v = 31'd611382493;
      4'd14: v = 31'd585461881;
      4'd15: v = 31'd560640218;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/pge_cell.sv
// One direction cell: offset and wrap, square, weight, accumulate.
// Four registered stages. Depends on pge_pkg.
module pge_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pge_pkg::CfgW-1:0]     setup,
  input  logic signed [pge_pkg::CoordW-1:0] coord,
  input  logic [pge_pkg::AccW-1:0]     acc_in,
  output logic [pge_pkg::AccW-1:0]     acc_out
);
  import pge_pkg::*;

  logic signed [15:0] center;
  logic [15:0] len, inv;
  logic signed [17:0] d0, d1, twod;
  logic signed [16:0] dx_r;
  logic [AccW-1:0] acc1_r, acc2_r, acc3_r;
  logic [16:0] mag;
  logic [33:0] sq_r;
  logic [49:0] prod_r;
  logic [15:0] inv1_r, inv2_r;

  assign center = setup[15:0];
  assign len    = setup[31:16];
  assign inv    = setup[47:32];

  always_comb begin
    d0 = 18'(coord) - 18'(center);
    twod = d0 <<< 1;
    d1 = d0;
    if (len != 16'd0) begin
      if (twod >= $signed({2'b00, len})) d1 = d0 - $signed({2'b00, len});
      else if (twod < -$signed({2'b00, len})) d1 = d0 + $signed({2'b00, len});
    end
  end

  assign mag = dx_r[16] ? 17'(-dx_r) : 17'(dx_r);

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= 17'(d1);
      inv1_r <= inv;
      acc1_r <= acc_in;
      sq_r   <= 34'(mag) * 34'(mag);
      inv2_r <= inv1_r;
      acc2_r <= acc1_r;
      prod_r <= 50'(sq_r) * 50'(inv2_r);
      acc3_r <= acc2_r;
      acc_out <= acc3_r + prod_r;
    end
  end
endmodule

>>> rtl/pge_exp.sv
// exp(-a) to Q1.15 with table and cubic series, floor add and saturation.
// Pipelined, at most one multiply per stage. Depends on pge_pkg.
module pge_exp (
  input  logic                     clk,
  input  logic                     en,
  input  logic [pge_pkg::AccW-1:0] acc,
  input  logic [15:0]              floor_lvl,
  output logic [pge_pkg::OutW-1:0] result
);
  import pge_pkg::*;

  logic zero1_r, zero2_r, zero3_r, zero4_r, zero5_r, zero6_r, zero7_r;
  logic [32:0] b_r;
  logic [4:0] n2_r, n3_r, n4_r, n5_r, n6_r, n7_r;
  logic [3:0] s2_r, s3_r, s4_r, s5_r;
  logic [29:0] y3_r, y4_r, y5_r;
  logic [30:0] yy4_r, y2_5_r;
  logic [29:0] ylin_r;
  logic [17:0] cube_r;
  logic [30:0] p6_r;
  logic [3:0] s6_r;
  logic [30:0] m7_r;
  logic [17:0] y3c;
  logic [60:0] y2w;
  logic [60:0] y3w;
  logic [30:0] pv;
  logic [61:0] mw;
  logic [16:0] env;
  logic [17:0] sum;
  logic [23:0] r2;
  logic [53:0] yw;

  assign r2 = b_r[23:0];
  assign yw = 54'(r2) * 54'(Ln2Q30);
  assign y2w = 61'(y4_r) * 61'(y4_r);
  assign y3w = 61'(yy4_r) * 61'(y5_r);
  assign y3c = 18'((36'(cube_r) * 36'(Recip6)) >> 20);
  assign pv = OneQ30 + (y2_5_r >> 1) - 31'(ylin_r) - 31'(y3c);
  assign mw = 62'(pow2_neg(s6_r)) * 62'(p6_r);

  always_comb begin
    logic [5:0] sh;
    logic [47:0] t;
    sh = 6'd15 + 6'(n7_r);
    t = (48'(m7_r) + (48'd1 << (sh - 6'd1))) >> sh;
    env = zero7_r ? 17'd0 : 17'(t);
    sum = 18'(env) + 18'(floor_lvl);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero1_r <= acc >= ExpCutoff;
      // below the cutoff the exponent fits in 32 bits
      b_r     <= 33'((63'(acc[31:0]) * 63'(Log2eQ30)) >> 30);
      zero2_r <= zero1_r;
      n2_r <= b_r[32:28];
      s2_r <= b_r[27:24];
      y3_r <= 30'(yw >> 28);
      zero3_r <= zero2_r; n3_r <= n2_r; s3_r <= s2_r;
      y4_r <= y3_r;
      zero4_r <= zero3_r; n4_r <= n3_r; s4_r <= s3_r;
      yy4_r <= 31'(y2w >> 30);
      y5_r <= y4_r;
      y2_5_r <= yy4_r;
      ylin_r <= y5_r;
      cube_r <= 18'(y3w >> 30);
      zero5_r <= zero4_r; n5_r <= n4_r; s5_r <= s4_r;
      p6_r <= pv;
      s6_r <= s5_r; n6_r <= n5_r; zero6_r <= zero5_r;
      m7_r <= 31'(mw >> 30);
      n7_r <= n6_r; zero7_r <= zero6_r;
      result <= (sum > 18'(OutMax)) ? OutMax : 17'(sum);
    end
  end
endmodule

>>> rtl/periodic_gaussian_envelope_top.sv
// Periodic Gaussian envelope, top level: row of direction cells then exp unit.
// Each input beat runs through the cells and exp unit to the output register.
// Throughput one beat per cycle; the whole pipe advances when not stalled.
// An output skid register lets input be taken while a result waits.
// Reset (rst_n, synchronous) clears setup, floor and valid registers.
module periodic_gaussian_envelope_top #(
  parameter int NUM_DIRS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // coord_x, coord_y, coord_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // profile_value, zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import pge_pkg::*;

  localparam int Lat = 4 * NUM_DIRS + 9;

  logic [CfgW-1:0] setup_r [NUM_DIRS];
  logic [15:0] floor_r;
  logic [Lat-1:0] vld_r;
  logic [AccW-1:0] acc [NUM_DIRS+1];
  logic signed [CoordW-1:0] crd [NUM_DIRS][NUM_DIRS];
  logic en;
  logic [OutW-1:0] res;
  logic skid_v_r;
  logic [OutW-1:0] skid_r;

  assign en = !vld_r[Lat-1] || !skid_v_r || out_tready;
  assign in_tready = en;
  assign acc[0] = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIRS; i++) setup_r[i] <= '0;
      floor_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegFloor) floor_r <= cfg_data[15:0];
      for (int i = 0; i < NUM_DIRS; i++)
        if (32'(cfg_index) == i) setup_r[i] <= cfg_data;
    end
  end

  // coordinate for direction d delayed to meet its cell
  for (genvar d = 0; d < NUM_DIRS; d++) begin : g_dir
    always_ff @(posedge clk) begin
      if (en) crd[d][0] <= in_tdata[16*d +: 16];
    end
    for (genvar k = 1; k <= d; k++) begin : g_dly
      for (genvar j = 0; j < 4; j++) begin : g_st
        logic signed [15:0] t_r;
        if (j == 0) begin : g_a
          always_ff @(posedge clk) if (en) t_r <= crd[d][k-1];
        end else begin : g_b
          always_ff @(posedge clk) if (en) t_r <= g_st[j-1].t_r;
        end
      end
      assign crd[d][k] = g_st[3].t_r;
    end
    pge_cell u_cell (
      .clk(clk), .en(en), .setup(setup_r[d]),
      .coord(d == 0 ? crd[d][0] : crd[d][d]),
      .acc_in(acc[d]), .acc_out(acc[d+1])
    );
  end

  pge_exp u_exp (
    .clk(clk), .en(en), .acc(acc[NUM_DIRS]), .floor_lvl(floor_r), .result(res)
  );

  // skid holds a beat when the last stage is not taken; on a pop with the
  // last stage valid, that beat moves into the skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) vld_r <= {vld_r[Lat-2:0], in_tvalid};
      if (out_tready) skid_v_r <= skid_v_r && vld_r[Lat-1];
      else skid_v_r <= skid_v_r || vld_r[Lat-1];
    end
  end
  always_ff @(posedge clk)
    if (!skid_v_r || out_tready) skid_r <= res;

  assign out_tvalid = skid_v_r || vld_r[Lat-1];
  assign out_tdata = {7'd0, skid_v_r ? skid_r : res};

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:0] <= OutMax) else $error("range");
  a_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> vld_r[Lat-1] || out_tvalid) else $error("skid");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_tready |=> skid_v_r) else $error("hold");
endmodule

>>> tb/periodic_gaussian_envelope_top_tb.sv
// Testbench for periodic_gaussian_envelope_top: directed and random points, checked
// beat by beat against a fixed-point predictor of the envelope held in this file.
// Depends on rtl/pge_pkg.sv and rtl/periodic_gaussian_envelope_top.sv.
module periodic_gaussian_envelope_top_tb;
  import pge_pkg::*;

  localparam int NUM_DIRS   = 3;
  localparam int PIPE_DEPTH = 4 * NUM_DIRS + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 12;
  localparam int PTS_PER_PHASE = 136;
  localparam logic [1:0] RegDir0 = 2'd0;

  localparam longint unsigned Log2e = 64'd1549082005;
  localparam longint unsigned Ln2   = 64'd744261118;
  localparam longint unsigned One30 = 64'd1073741824;
  localparam longint unsigned Cutoff = 64'd12 << 28;
  localparam longint unsigned Pow2NegQ30 [16] = '{
    1073741824, 1028218693, 984625594, 942880699,
    902905651,  864625413,  827968132, 792865000,
    759250125,  727060410,  696235434, 666717336,
    638450708,  611382493,  585461881, 560640218
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // coord_x, coord_y, coord_z
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // profile_value, zero pad
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;

  logic [47:0] dir_setup_m [3];
  logic [15:0] floor_m;

  logic [47:0] point_q [$];
  logic [16:0] profile_q [$];
  bit          in_taken;
  int          tx_idle_pct, rx_idle_pct;
  int          hold_req, hold_cnt;
  int          n_in, n_out, n_err, n_zero, n_wrap;
  int          cycles;

  periodic_gaussian_envelope_top #(.NUM_DIRS(NUM_DIRS)) u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // exp(-a) for an unsigned Q.28 exponent, rounded to Q1.15
  function automatic longint unsigned exp_neg_q15(input longint unsigned a);
    longint unsigned b, r, y, y2, y3, p, m;
    int n, sh;
    if (a >= Cutoff) return 0;
    b  = (a * Log2e) >> 30;
    n  = int'(b >> 28);
    r  = b & 64'hFF_FFFF;
    y  = (r * Ln2) >> 28;
    y2 = (y * y) >> 30;
    y3 = (y2 * y) >> 30;
    p  = One30 + (y2 >> 1) - y - y3 / 6;
    m  = (Pow2NegQ30[(b >> 24) & 64'hF] * p) >> 30;
    sh = 15 + n;
    return (m + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [16:0] envelope_plus_floor(input logic [47:0] pt);
    longint unsigned acc, mag, sum;
    int dx, len, ctr;
    bit wrapped;
    acc = 0;
    wrapped = 0;
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (dir_setup_m[d][47:32] != 0) begin
        ctr = int'($signed(dir_setup_m[d][15:0]));
        len = int'(dir_setup_m[d][31:16]);
        dx  = int'($signed(pt[16*d +: 16])) - ctr;
        if (len != 0) begin
          if (2 * dx >= len) begin
            dx -= len;
            wrapped = 1;
          end else if (2 * dx < -len) begin
            dx += len;
            wrapped = 1;
          end
        end
        mag = longint'(dx < 0 ? -dx : dx);
        acc += mag * mag * longint'(dir_setup_m[d][47:32]);
      end
    end
    if (wrapped) n_wrap++;
    sum = exp_neg_q15(acc);
    if (sum == 0) n_zero++;
    sum += floor_m;
    if (sum > 65536) sum = 65536;
    return sum[16:0];
  endfunction

  // input acceptance, prediction and result checking
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      profile_q.push_back(envelope_plus_floor(in_tdata));
      n_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      if (profile_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
        n_err++;
      end else begin
        logic [16:0] want;
        want = profile_q.pop_front();
        if (out_tdata !== {7'd0, want}) begin
          $display("%0t: profile_value mismatch, expected %0d, actual %0d (raw %h)",
                   $time, want, out_tdata[16:0], out_tdata);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, profile_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // point driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (point_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_tdata  <= point_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic load_regs(input logic [47:0] d0, d1, d2, input logic [15:0] fl);
    logic [47:0] vals [4];
    vals = '{d0, d1, d2, {32'd0, fl}};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= RegDir0 + 2'(i);
      cfg_data  <= vals[i];
      if (2'(i) == RegFloor) floor_m = fl;
      else dir_setup_m[i] = vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pt(input logic [15:0] x, y, z);
    point_q.push_back({z, y, x});
  endtask

  // sender pauses here until every expected result is back
  task automatic drain();
    do @(posedge clk);
    while (point_q.size() != 0 || in_tvalid || profile_q.size() != 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_setup();
    logic [15:0] len, inv;
    case ($urandom_range(4))
      0:       len = 16'd0;
      1:       len = 16'hFFFF;
      2:       len = 16'($urandom_range(256, 4096));
      default: len = 16'($urandom);
    endcase
    case ($urandom_range(9))
      0:       inv = 16'd0;
      1:       inv = 16'hFFFF;
      2:       inv = 16'($urandom);
      3:       inv = 16'd4096;
      default: inv = 16'($urandom_range(1, 8192));
    endcase
    return {inv, len, 16'($urandom)};
  endfunction

  function automatic logic [15:0] rand_coord(input logic [47:0] setup);
    int ctr, len;
    ctr = int'($signed(setup[15:0]));
    len = int'(setup[31:16]);
    case ($urandom_range(9))
      6, 7:    return 16'(ctr + ($urandom_range(1) ? len / 2 : -len / 2)
                       + $urandom_range(64) - 32);
      8:       return 16'($urandom);
      9:       return 16'(ctr + ($urandom_range(1) ? len : -len) + $urandom_range(512) - 256);
      default: return 16'(ctr + $urandom_range(1536) - 768);
    endcase
  endfunction

  initial begin
    logic [15:0] fl;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 0;
    hold_cnt = 0;
    tx_idle_pct = 30;
    rx_idle_pct = 61;
    for (int d = 0; d < 3; d++) dir_setup_m[d] = '0;
    floor_m = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // plain Gaussian in x, periodic y, z skipped
    load_regs({16'd4096, 16'd0, 16'd0}, {16'h2000, 16'h0800, 16'h0100},
              {16'd0, 16'h0400, 16'd0}, 16'd0);
    push_pt(16'h0000, 16'h0100, 16'h0000);
    push_pt(16'h7FFF, 16'h0100, 16'h7FFF);
    push_pt(16'h8000, 16'h0100, 16'h8000);
    push_pt(16'h0080, 16'h0100, 16'h1234);
    push_pt(16'hFF80, 16'h0140, 16'hFFFF);
    push_pt(16'h0000, 16'h0500, 16'h0000);  // offset exactly half a box
    push_pt(16'h0000, 16'h04FF, 16'h0000);
    push_pt(16'h0000, 16'hFD00, 16'h0000);  // exactly minus half a box
    push_pt(16'h0000, 16'hFCFF, 16'h0000);
    push_pt(16'h0000, 16'h0900, 16'h0000);  // one whole box away
    push_pt(16'h0000, 16'h0D00, 16'h0000);  // exactly 1.5 boxes away, stays outside
    push_pt(16'h0000, 16'hF500, 16'h0000);
    drain();

    // extreme centers and widths, floor at one
    load_regs({16'hFFFF, 16'hFFFF, 16'h8000}, {16'h0001, 16'h0000, 16'h7FFF},
              {16'h1000, 16'h0100, 16'h0000}, 16'h8000);
    push_pt(16'h8000, 16'h7FFF, 16'h0000);
    push_pt(16'h7FFF, 16'h8000, 16'h0080);
    push_pt(16'h8001, 16'h7F00, 16'hFF81);
    push_pt(16'h0000, 16'h0000, 16'h007F);
    push_pt(16'h7FFF, 16'h7FFF, 16'h8000);
    drain();

    // all directions skipped
    load_regs({16'd0, 16'hFFFF, 16'h7FFF}, {16'd0, 16'd0, 16'h8000},
              {16'd0, 16'hFFFF, 16'hFFFF}, 16'h7FFF);
    push_pt(16'h7FFF, 16'h8000, 16'hFFFF);
    push_pt(16'h0000, 16'hFFFF, 16'h8000);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(3))
        0:       fl = 16'd0;
        1:       fl = 16'h8000;
        default: fl = 16'($urandom_range(32768));
      endcase
      load_regs(rand_setup(), rand_setup(), rand_setup(), fl);
      if (ph < 4) begin
        tx_idle_pct = 30;
        rx_idle_pct = 61;
      end else if (ph < 8) begin
        tx_idle_pct = 61;
        rx_idle_pct = 30;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int i = 0; i < PTS_PER_PHASE; i++)
        push_pt(rand_coord(dir_setup_m[0]), rand_coord(dir_setup_m[1]),
                rand_coord(dir_setup_m[2]));
      // back up the pipe while points keep coming
      if (ph == 1 || ph == 9) begin
        @(posedge clk);
        hold_req = 400;
      end
      drain();
    end

    $display("Checked %0d of %0d points over %0d register settings;", n_out, n_in,
             RAND_PHASES + 3);
    $display("%0d wrapped a periodic offset, %0d hit the exponent cutoff.", n_wrap, n_zero);
    if (n_err == 0 && profile_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pge_pkg.sv
rtl/pge_cell.sv
rtl/pge_exp.sv
rtl/periodic_gaussian_envelope_top.sv
tb/periodic_gaussian_envelope_top_tb.sv
